@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define TSW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TSW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/tsw_pkg.sv @@
// ----------------------------------------------------------------------------
// tsw_pkg
// Shared constants and types of the triangle span walker.
// ----------------------------------------------------------------------------
package tsw_pkg;

    // Default coordinate width
    localparam int COORD_BITS_DEFAULT = 10;

    // Item operation codes
    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } op_t;

    // Control from the walker to each edge unit
    typedef struct packed
    {
        logic load;     // latch a new edge and start its slope division
        logic advance;  // move the edge offset on by one row
    } edge_ctrl_t;

endpackage

@@ rtl/core/tsw_in_if.sv @@
// ----------------------------------------------------------------------------
// tsw_in_if
// Input channel: load or step items with three vertices.
// ----------------------------------------------------------------------------
interface tsw_in_if #(
    parameter int COORD_BITS = tsw_pkg::COORD_BITS_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [COORD_BITS-1:0] vert_a_x;
    logic [COORD_BITS-1:0] vert_a_y;
    logic [COORD_BITS-1:0] vert_b_x;
    logic [COORD_BITS-1:0] vert_b_y;
    logic [COORD_BITS-1:0] vert_c_x;
    logic [COORD_BITS-1:0] vert_c_y;

    modport source
    (
        output valid, op, vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y,
        input  ready
    );

    modport sink
    (
        input  valid, op, vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y,
        output ready
    );
endinterface

@@ rtl/core/tsw_out_if.sv @@
// ----------------------------------------------------------------------------
// tsw_out_if
// Output channel: one span per transfer.
// ----------------------------------------------------------------------------
interface tsw_out_if #(
    parameter int COORD_BITS = tsw_pkg::COORD_BITS_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] row_y;
    logic [COORD_BITS-1:0] span_start;
    logic [COORD_BITS-1:0] span_end;
    logic                  last_span;

    modport source
    (
        output valid, row_y, span_start, span_end, last_span,
        input  ready
    );

    modport sink
    (
        input  valid, row_y, span_start, span_end, last_span,
        output ready
    );
endinterface

@@ rtl/core/tsw_divider.sv @@
// ----------------------------------------------------------------------------
// tsw_divider
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module tsw_divider #(
    parameter int COORD_BITS = tsw_pkg::COORD_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] dividend,
    input  logic [COORD_BITS-1:0] divisor,
    output logic                  busy,
    output logic [COORD_BITS-1:0] quotient,
    output logic [COORD_BITS-1:0] remainder
);
    localparam int CNT_W = $clog2(COORD_BITS + 1);

    logic [COORD_BITS-1:0] dividend_reg, dividend_next;
    logic [COORD_BITS-1:0] rem_reg, rem_next;
    logic [COORD_BITS-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [COORD_BITS:0]   trial;
    logic [COORD_BITS:0]   diff;
    logic                  fits;

    // Trial subtract of the shifted partial remainder
    assign trial = {rem_reg, dividend_reg[COORD_BITS-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        count_next    = count_reg;
        if (start)
        begin
            dividend_next = dividend;
            rem_next      = '0;
            quo_next      = '0;
            count_next    = CNT_W'(COORD_BITS);
        end
        else if (count_reg != '0)
        begin
            dividend_next = {dividend_reg[COORD_BITS-2:0], 1'b0};
            rem_next      = fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
            quo_next      = {quo_reg[COORD_BITS-2:0], fits};
            count_next    = count_reg - CNT_W'(1);
        end
    end

    // Hold the bit counter; data registers need no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
    end

    assign busy      = (count_reg != '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

`include "assert_macros.svh"

    `TSW_ASSERT_NOW(a_no_restart, start, !busy, "divider restarted while busy")
    `TSW_ASSERT_NEXT(a_start_runs, start, busy && count_reg == CNT_W'(COORD_BITS),
        "divider did not begin a full pass")
    `TSW_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CNT_W'(COORD_BITS),
        "divider bit counter out of range")

endmodule

@@ rtl/core/tsw_edge.sv @@
// ----------------------------------------------------------------------------
// tsw_edge
// One triangle edge: slope split into whole and fractional step at load,
// then the offset trunc(i*dx/dy) kept as quotient and remainder per row.
// ----------------------------------------------------------------------------
module tsw_edge #(
    parameter int COORD_BITS = tsw_pkg::COORD_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tsw_pkg::edge_ctrl_t    ctrl,
    input  logic [COORD_BITS-1:0]  x_from,
    input  logic [COORD_BITS-1:0]  x_to,
    input  logic [COORD_BITS-1:0]  dy,
    output logic                   busy,
    output logic signed [COORD_BITS:0] offset
);
    import tsw_pkg::*;

    logic                  neg_reg;
    logic [COORD_BITS-1:0] dy_reg;
    logic [COORD_BITS-1:0] q_reg, q_next;
    logic [COORD_BITS-1:0] r_reg, r_next;
    logic                  neg_load;
    logic [COORD_BITS-1:0] mag_load;
    logic [COORD_BITS-1:0] step_q;
    logic [COORD_BITS-1:0] step_r;
    logic [COORD_BITS:0]   r_sum;
    logic [COORD_BITS:0]   r_wrap;
    logic                  carry;

    // Magnitude and sign of dx
    assign neg_load = (x_to < x_from);
    assign mag_load = neg_load ? (x_from - x_to) : (x_to - x_from);

    tsw_divider #(
        .COORD_BITS (COORD_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctrl.load),
        .dividend  (mag_load),
        .divisor   (dy_reg),
        .busy      (busy),
        .quotient  (step_q),
        .remainder (step_r)
    );

    // Advance: add the fractional step, carry once into the whole part
    assign r_sum  = {1'b0, r_reg} + {1'b0, step_r};
    assign r_wrap = r_sum - {1'b0, dy_reg};
    assign carry  = (r_sum >= {1'b0, dy_reg});

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        if (ctrl.load)
        begin
            q_next = '0;
            r_next = '0;
        end
        else if (ctrl.advance)
        begin
            q_next = q_reg + step_q + {{(COORD_BITS-1){1'b0}}, carry};
            r_next = carry ? r_wrap[COORD_BITS-1:0] : r_sum[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            neg_reg <= neg_load;
            dy_reg  <= dy;
        end
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign offset = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

`include "assert_macros.svh"

    `TSW_ASSERT_NEXT(a_rem_bound, ctrl.advance && !ctrl.load && dy_reg != '0,
        r_reg < dy_reg, "edge remainder escaped its divisor")
    `TSW_ASSERT_NOW(a_ctrl_excl, 1'b1, !(ctrl.load && ctrl.advance),
        "edge loaded and advanced together")
    `TSW_ASSERT_NOW(a_no_step_busy, ctrl.advance, !busy,
        "edge advanced during slope division")

endmodule

@@ rtl/core/triangle_span_walker.sv @@
// ----------------------------------------------------------------------------
// triangle_span_walker
// Walks the top part of a triangle and hands out one span per step item.
// ----------------------------------------------------------------------------
// A load item sorts the three vertices by y and then splits each edge slope
// dx/dy into a whole and a fractional step with a bit-serial divider, one
// quotient bit per cycle for both edges in parallel: a load holds the input
// until both dividers are done and gives no span. After that every step
// item, while rows remain, yields one span [start, end) from the top row
// down to the middle row, exclusive, with last_span set on the final one;
// steps with no rows left give nothing. Each span sits in an output
// register, so a step is taken while the previous span waits, as long as
// the sink takes it in the same cycle.
// ----------------------------------------------------------------------------
module triangle_span_walker #(
    parameter int COORD_BITS = tsw_pkg::COORD_BITS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    tsw_in_if.sink     in_ch,
    tsw_out_if.source  out_ch
);
    import tsw_pkg::*;

    typedef enum logic
    {
        ST_IDLE,
        ST_LOAD
    } state_t;

    state_t                state_reg, state_next;
    logic [COORD_BITS-1:0] top_x_reg, top_x_next;
    logic [COORD_BITS-1:0] top_y_reg, top_y_next;
    logic [COORD_BITS-1:0] row_index_reg, row_index_next;
    logic [COORD_BITS-1:0] rows_total_reg, rows_total_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] row_y_reg, row_y_next;
    logic [COORD_BITS-1:0] start_reg, start_next;
    logic [COORD_BITS-1:0] end_reg, end_next;
    logic                  last_reg, last_next;

    logic                  in_ready;
    logic                  in_accept;
    logic                  rows_left;
    logic [COORD_BITS-1:0] row_inc;
    edge_ctrl_t            edge_ctrl;
    logic                  left_busy;
    logic                  right_busy;
    logic signed [COORD_BITS:0] left_off;
    logic signed [COORD_BITS:0] right_off;
    logic signed [COORD_BITS:0] lo_off;
    logic signed [COORD_BITS:0] hi_off;

    // Sorted vertices
    logic [COORD_BITS-1:0] sx0, sy0, sx1, sy1, sx2, sy2, tx, ty;

    // Order the vertices by y with three strict compare-and-swap stages
    always_comb
    begin
        tx  = '0;
        ty  = '0;
        sx0 = in_ch.vert_a_x;
        sy0 = in_ch.vert_a_y;
        sx1 = in_ch.vert_b_x;
        sy1 = in_ch.vert_b_y;
        sx2 = in_ch.vert_c_x;
        sy2 = in_ch.vert_c_y;
        if (sy0 > sy1)
        begin
            tx = sx0; ty = sy0;
            sx0 = sx1; sy0 = sy1;
            sx1 = tx;  sy1 = ty;
        end
        if (sy0 > sy2)
        begin
            tx = sx0; ty = sy0;
            sx0 = sx2; sy0 = sy2;
            sx2 = tx;  sy2 = ty;
        end
        if (sy1 > sy2)
        begin
            tx = sx1; ty = sy1;
            sx1 = sx2; sy1 = sy2;
            sx2 = tx;  sy2 = ty;
        end
    end

    // Accept only when idle and the output register is free or draining
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ch.ready);
    assign in_accept = in_ch.valid && in_ready;
    assign rows_left = (row_index_reg < rows_total_reg);
    assign row_inc   = row_index_reg + COORD_BITS'(1);

    assign edge_ctrl.load    = in_accept && (in_ch.op == OP_LOAD);
    assign edge_ctrl.advance = in_accept && (in_ch.op == OP_STEP) && rows_left;

    tsw_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (edge_ctrl),
        .x_from (sx0),
        .x_to   (sx1),
        .dy     (sy1 - sy0),
        .busy   (left_busy),
        .offset (left_off)
    );

    tsw_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (edge_ctrl),
        .x_from (sx0),
        .x_to   (sx2),
        .dy     (sy2 - sy0),
        .busy   (right_busy),
        .offset (right_off)
    );

    // Put the smaller offset first
    assign lo_off = (left_off > right_off) ? right_off : left_off;
    assign hi_off = (left_off > right_off) ? left_off : right_off;

    // Walk control and output register
    always_comb
    begin
        state_next      = state_reg;
        top_x_next      = top_x_reg;
        top_y_next      = top_y_reg;
        row_index_next  = row_index_reg;
        rows_total_next = rows_total_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        row_y_next      = row_y_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        last_next       = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (edge_ctrl.load)
                begin
                    top_x_next      = sx0;
                    top_y_next      = sy0;
                    row_index_next  = '0;
                    rows_total_next = sy1 - sy0;
                    state_next      = ST_LOAD;
                end
                else if (edge_ctrl.advance)
                begin
                    out_valid_next = 1'b1;
                    row_y_next     = top_y_reg + row_index_reg;
                    start_next     = top_x_reg + lo_off[COORD_BITS-1:0];
                    end_next       = top_x_reg + hi_off[COORD_BITS-1:0];
                    last_next      = (row_inc == rows_total_reg);
                    row_index_next = row_inc;
                end
            end
            ST_LOAD:
            begin
                if (!left_busy && !right_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            top_x_reg      <= '0;
            top_y_reg      <= '0;
            row_index_reg  <= '0;
            rows_total_reg <= '0;
            out_valid_reg  <= 1'b0;
            row_y_reg      <= '0;
            start_reg      <= '0;
            end_reg        <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            top_x_reg      <= top_x_next;
            top_y_reg      <= top_y_next;
            row_index_reg  <= row_index_next;
            rows_total_reg <= rows_total_next;
            out_valid_reg  <= out_valid_next;
            row_y_reg      <= row_y_next;
            start_reg      <= start_next;
            end_reg        <= end_next;
            last_reg       <= last_next;
        end
    end

    assign in_ch.ready       = in_ready;
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.row_y      = row_y_reg;
    assign out_ch.span_start = start_reg;
    assign out_ch.span_end   = end_reg;
    assign out_ch.last_span  = last_reg;

`include "assert_macros.svh"

    `TSW_ASSERT_NOW(a_edges_in_step, 1'b1, left_busy == right_busy,
        "edge dividers out of step")
    `TSW_ASSERT_NOW(a_row_bound, 1'b1, row_index_reg <= rows_total_reg,
        "row index ran past the middle row")
    `TSW_ASSERT_NEXT(a_step_emits, edge_ctrl.advance, out_valid_reg,
        "step with rows left gave no span")

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the triangle span walker.
// ----------------------------------------------------------------------------
// A table of directed load and step items runs first. Its obvious spans are
// typed in by hand; the rest are checked against a span predictor kept in the
// bench. Random triangle walks follow, mostly a load followed by enough steps
// to finish the top part, mixed with stray steps, cut-short walks and
// full-range loads. Both channels idle and stall at random, apart from one
// quiet stretch, and the sender once holds off until every span has drained.
// ----------------------------------------------------------------------------
module tb_top;

    import tsw_pkg::*;

    localparam int CB              = COORD_BITS_DEFAULT;
    localparam int WALK_ITEMS      = 1050;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 3 * CB;
    localparam int IDLE_PERCENT    = 31;
    localparam int COORD_MAX       = (1 << CB) - 1;

    typedef enum logic [1:0]
    {
        CHK_MODEL,  // expectation from the predictor
        CHK_NONE,   // no span may follow this item
        CHK_SPAN    // expectation typed into the table
    } chk_t;

    typedef struct packed
    {
        op_t           op;
        logic [CB-1:0] ax;
        logic [CB-1:0] ay;
        logic [CB-1:0] bx;
        logic [CB-1:0] by;
        logic [CB-1:0] cx;
        logic [CB-1:0] cy;
    } walk_item_t;

    typedef struct packed
    {
        logic [CB-1:0] row_y;
        logic [CB-1:0] span_start;
        logic [CB-1:0] span_end;
        logic          last_span;
    } span_t;

    typedef struct packed
    {
        walk_item_t item;
        chk_t       chk;
        span_t      span;
    } walk_row_t;

    localparam span_t NO_SPAN = '0;

    logic clk;
    logic rst_n;

    tsw_in_if  #(.COORD_BITS(CB)) in_ch ();
    tsw_out_if #(.COORD_BITS(CB)) out_ch ();

    triangle_span_walker #(.COORD_BITS(CB)) dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Directed items: extremes, ties, negative slopes, vertical edges, restarts
    walk_row_t directed_rows [25] = '{
        '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, CHK_NONE, NO_SPAN},                 // nothing loaded
        '{'{OP_LOAD, 1023, 1023, 1023, 1023, 1023, 1023}, CHK_NONE, NO_SPAN},
        '{'{OP_STEP, 1023, 1023, 1023, 1023, 1023, 1023}, CHK_NONE, NO_SPAN}, // flat
        '{'{OP_LOAD, 0, 0, 1023, 1, 0, 1023}, CHK_NONE, NO_SPAN},
        '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, CHK_SPAN, '{0, 0, 0, 1'b1}},
        '{'{OP_STEP, 682, 341, 682, 341, 682, 341}, CHK_NONE, NO_SPAN},     // walk done
        '{'{OP_LOAD, 1023, 1023, 0, 0, 512, 0}, CHK_NONE, NO_SPAN},         // tied top
        '{'{OP_STEP, 341, 682, 341, 682, 341, 682}, CHK_NONE, NO_SPAN},
        '{'{OP_LOAD, 100, 50, 200, 50, 300, 10}, CHK_NONE, NO_SPAN},        // tied bottom
        '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, CHK_MODEL, NO_SPAN},
        '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, CHK_MODEL, NO_SPAN},
        '{'{OP_LOAD, 1023, 0, 0, 3, 1023, 4}, CHK_NONE, NO_SPAN},           // restart
        '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, CHK_SPAN, '{0, 1023, 1023, 1'b0}},
        '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, CHK_MODEL, NO_SPAN},
        '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, CHK_MODEL, NO_SPAN},
        '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, CHK_NONE, NO_SPAN},
        '{'{OP_LOAD, 10, 0, 3, 2, 20, 4}, CHK_NONE, NO_SPAN},               // odd negative dx
        '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, CHK_MODEL, NO_SPAN},
        '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, CHK_MODEL, NO_SPAN},
        '{'{OP_LOAD, 500, 100, 500, 105, 500, 200}, CHK_NONE, NO_SPAN},     // vertical
        '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, CHK_MODEL, NO_SPAN},
        '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, CHK_MODEL, NO_SPAN},
        '{'{OP_LOAD, 0, 1023, 1023, 0, 700, 512}, CHK_NONE, NO_SPAN},       // full sort
        '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, CHK_MODEL, NO_SPAN},
        '{'{OP_STEP, 0, 0, 0, 0, 0, 0}, CHK_MODEL, NO_SPAN}
    };

    // Predicted walk state
    logic        [CB-1:0] apex_x    = '0;
    logic        [CB-1:0] apex_y    = '0;
    logic        [CB-1:0] row_idx   = '0;
    logic        [CB-1:0] row_cnt   = '0;
    logic signed [CB:0]   mid_dx    = '0;
    logic        [CB-1:0] mid_dy    = '0;
    logic signed [CB:0]   far_dx    = '0;
    logic        [CB-1:0] far_dy    = '0;

    span_t spans_due [$];
    int    err_count    = 0;
    int    walk_count   = 0;
    int    stall_cycles = 0;
    bit    quiet        = 1'b0;

    // Tag carried alongside each item, driven with it
    chk_t  cur_chk;
    span_t cur_span;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Span predictor
    // ------------------------------------------------------------------------
    function automatic longint edge_offset(logic [CB-1:0] row, logic signed [CB:0] dx,
                                           logic [CB-1:0] dy);
        if (dy == '0 || dx == '0)
            return 0;
        return (longint'(row) * longint'(dx)) / longint'(dy);
    endfunction

    task automatic predict_span(input walk_item_t it, output logic made, output span_t sp);
        logic [CB-1:0] ax, ay, bx, by, cx, cy, t;
        longint        lo, hi, swap;
        made = 1'b0;
        sp   = NO_SPAN;
        if (it.op == OP_LOAD)
        begin
            ax = it.ax; ay = it.ay; bx = it.bx; by = it.by; cx = it.cx; cy = it.cy;
            // Sort by y with the same strict compare-and-swap order as the walker
            if (ay > by)
            begin
                t = ay; ay = by; by = t; t = ax; ax = bx; bx = t;
            end
            if (ay > cy)
            begin
                t = ay; ay = cy; cy = t; t = ax; ax = cx; cx = t;
            end
            if (by > cy)
            begin
                t = by; by = cy; cy = t; t = bx; bx = cx; cx = t;
            end
            apex_x  = ax;
            apex_y  = ay;
            row_idx = '0;
            row_cnt = by - ay;
            mid_dx  = $signed({1'b0, bx}) - $signed({1'b0, ax});
            mid_dy  = by - ay;
            far_dx  = $signed({1'b0, cx}) - $signed({1'b0, ax});
            far_dy  = cy - ay;
        end
        else if (row_idx < row_cnt)
        begin
            lo = edge_offset(row_idx, mid_dx, mid_dy);
            hi = edge_offset(row_idx, far_dx, far_dy);
            if (lo > hi)
            begin
                swap = lo; lo = hi; hi = swap;
            end
            sp.row_y      = apex_y + row_idx;
            sp.span_start = CB'(longint'(apex_x) + lo);
            sp.span_end   = CB'(longint'(apex_x) + hi);
            row_idx       = row_idx + 1'b1;
            sp.last_span  = (row_idx == row_cnt);
            made          = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // Monitor: check spans, predict on accepted items, watch for a hang
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        span_t      got;
        span_t      want;
        span_t      calc;
        walk_item_t it;
        logic       made;
        if (rst_n)
        begin
            // Check each span transfer against the oldest expectation
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.row_y, out_ch.span_start, out_ch.span_end, out_ch.last_span};
                if (spans_due.size() == 0)
                    report_mismatch($sformatf("unexpected span row_y %0d [%0d,%0d) last %0b",
                                              got.row_y, got.span_start, got.span_end,
                                              got.last_span));
                else
                begin
                    want = spans_due.pop_front();
                    if (got.row_y !== want.row_y)
                        report_mismatch($sformatf("row_y got %0d expected %0d",
                                                  got.row_y, want.row_y));
                    if (got.span_start !== want.span_start)
                        report_mismatch($sformatf("span_start got %0d expected %0d (row %0d)",
                                                  got.span_start, want.span_start, want.row_y));
                    if (got.span_end !== want.span_end)
                        report_mismatch($sformatf("span_end got %0d expected %0d (row %0d)",
                                                  got.span_end, want.span_end, want.row_y));
                    if (got.last_span !== want.last_span)
                        report_mismatch($sformatf("last_span got %0b expected %0b (row %0d)",
                                                  got.last_span, want.last_span, want.row_y));
                end
            end

            // Predict on each item transfer
            if (in_ch.valid && in_ch.ready)
            begin
                it = '{op_t'(in_ch.op), in_ch.vert_a_x, in_ch.vert_a_y, in_ch.vert_b_x,
                       in_ch.vert_b_y, in_ch.vert_c_x, in_ch.vert_c_y};
                predict_span(it, made, calc);
                walk_count++;
                case (cur_chk)
                    CHK_MODEL: if (made) spans_due.push_back(calc);
                    CHK_SPAN:  spans_due.push_back(cur_span);
                    default:   ;
                endcase
            end

            // Count cycles with no transfer on either side
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Span sink: stall at random outside the quiet stretch
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
    end

    // ------------------------------------------------------------------------
    // Item source
    // ------------------------------------------------------------------------
    task automatic send_item(input walk_item_t it, input chk_t chk, input span_t typed);
        // Idle at random before the transfer
        while (!quiet && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.op       <= it.op;
        in_ch.vert_a_x <= it.ax;
        in_ch.vert_a_y <= it.ay;
        in_ch.vert_b_x <= it.bx;
        in_ch.vert_b_y <= it.by;
        in_ch.vert_c_x <= it.cx;
        in_ch.vert_c_y <= it.cy;
        cur_chk        <= chk;
        cur_span       <= typed;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    function automatic walk_item_t noise_step();
        walk_item_t it;
        it    = walk_item_t'(($bits(walk_item_t))'({$urandom, $urandom}));
        it.op = OP_STEP;
        return it;
    endfunction

    task automatic send_steps(input int count);
        for (int n = 0; n < count; n++)
            send_item(noise_step(), CHK_MODEL, NO_SPAN);
    endtask

    task automatic run_random_walks();
        int         orders [6][3] = '{'{0, 1, 2}, '{0, 2, 1}, '{1, 0, 2},
                                      '{1, 2, 0}, '{2, 0, 1}, '{2, 1, 0}};
        int         xs [3];
        int         ys [3];
        int         h, db, perm, pick, steps, tall_walks;
        bit         paused;
        walk_item_t it;
        tall_walks = 0;
        paused     = 1'b0;
        while (walk_count < WALK_ITEMS)
        begin
            // Hold one quiet stretch with no idling on either side
            quiet = (walk_count >= 400 && walk_count < 550);

            // Hold off once until every span has drained
            if (!paused && walk_count >= 700)
            begin
                paused = 1'b1;
                in_ch.valid <= 1'b0;
                @(posedge clk);
                while (spans_due.size() != 0)
                    @(posedge clk);
            end

            pick = $urandom_range(99);
            if (pick < 85)
            begin
                // Well-formed walk: top, middle and bottom in random order
                if (tall_walks < 2 && walk_count < WALK_ITEMS / 2 &&
                    $urandom_range(39) == 0)
                begin
                    h = $urandom_range(32, WALK_ITEMS / 4);
                    tall_walks++;
                end
                else
                    h = $urandom_range(0, 12);
                ys[0] = $urandom_range(0, COORD_MAX - h);
                ys[1] = ys[0] + h;
                db    = $urandom_range(0, 40);
                if (ys[1] + db > COORD_MAX)
                    db = COORD_MAX - ys[1];
                ys[2] = ys[1] + db;
                for (int k = 0; k < 3; k++)
                    xs[k] = $urandom_range(0, COORD_MAX);
                perm  = $urandom_range(0, 5);
                it.op = OP_LOAD;
                it.ax = CB'(xs[orders[perm][0]]);
                it.ay = CB'(ys[orders[perm][0]]);
                it.bx = CB'(xs[orders[perm][1]]);
                it.by = CB'(ys[orders[perm][1]]);
                it.cx = CB'(xs[orders[perm][2]]);
                it.cy = CB'(ys[orders[perm][2]]);
                send_item(it, CHK_MODEL, NO_SPAN);
                // Cut some walks short so the next load restarts them
                if ($urandom_range(9) == 0)
                    steps = $urandom_range(0, h);
                else
                    steps = h + $urandom_range(0, 2);
                send_steps(steps);
            end
            else if (pick < 93)
                send_steps($urandom_range(1, 3));
            else
            begin
                // Full-range load, walked only a little way
                it    = walk_item_t'(($bits(walk_item_t))'({$urandom, $urandom}));
                it.op = OP_LOAD;
                send_item(it, CHK_MODEL, NO_SPAN);
                send_steps($urandom_range(0, 6));
            end
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.op       = OP_LOAD;
        in_ch.vert_a_x = '0;
        in_ch.vert_a_y = '0;
        in_ch.vert_b_x = '0;
        in_ch.vert_b_y = '0;
        in_ch.vert_c_x = '0;
        in_ch.vert_c_y = '0;
        cur_chk        = CHK_MODEL;
        cur_span       = NO_SPAN;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed_rows[r])
            send_item(directed_rows[r].item, directed_rows[r].chk, directed_rows[r].span);

        run_random_walks();

        // Drain outstanding spans, then watch for stray ones
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (spans_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/tsw_pkg.sv
rtl/core/tsw_in_if.sv
rtl/core/tsw_out_if.sv
rtl/core/tsw_divider.sv
rtl/core/tsw_edge.sv
rtl/core/triangle_span_walker.sv
verif/tb_top.sv
